// ===== src/ght_pkg.sv =====
// shared types and constants of the generational handle table
`default_nettype none

package ght_pkg;

	// operation codes of an input transaction
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RESOLVE = 2'd1;
	localparam logic [1:0] OP_CONSUME = 2'd2;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_RANGE    = 3'd2,
		ST_STALE    = 3'd3,
		ST_NOT_LIVE = 3'd4,
		ST_TAG      = 3'd5
	} status_t;

	localparam int SLOT_INDEX_W = 10;

	// configuration register map (index taken from the 8-byte word address)
	localparam int          CFG_ADDR_W        = 4;
	localparam logic [0:0]  REG_COOKIE_SECRET = 1'b0;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_B  = 64'h94D049BB133111EB;

	// result fields carried alongside the cookie hash
	typedef struct packed {
		status_t                  status;
		logic [SLOT_INDEX_W-1:0]  slot_index;
		logic [31:0]              slot_generation;
		logic [31:0]              stored_tag;
		logic                     cookie_en;
	} res_t;

endpackage

`default_nettype wire

// ===== src/ght_mix64.sv =====
// pipelined splitmix64 finalizer with a side payload
`default_nettype none

module ght_mix64 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [63:0]   in_x,
	input  wire ght_pkg::res_t in_res,
	output logic               out_valid,
	output ght_pkg::res_t      out_res,
	output logic [63:0]        out_hash
);

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ght_pkg::res_t res_s1, res_s2, res_s3, res_s4, res_s5;
	logic [63:0]   z_s1, w_s3, u_s5;
	logic [63:0]   p0_s2, p0_s4;
	logic [31:0]   p1_s2, p2_s2, p1_s4, p2_s4;

	logic [63:0]   y, v;
	logic [63:0]   p0_a, p0_b;
	logic [31:0]   p1_a, p2_a, p1_b, p2_b;
	logic [31:0]   cross_a, cross_b;

	// first round: y = z ^ (z >> 30), times MIX_A split into 32-bit products
	assign y    = z_s1 ^ (z_s1 >> 30);
	assign p0_a = y[31:0] * ght_pkg::MIX_A[31:0];
	assign p1_a = y[31:0] * ght_pkg::MIX_A[63:32];
	assign p2_a = y[63:32] * ght_pkg::MIX_A[31:0];
	assign cross_a = p1_s2 + p2_s2;

	// second round with MIX_B
	assign v    = w_s3 ^ (w_s3 >> 27);
	assign p0_b = v[31:0] * ght_pkg::MIX_B[31:0];
	assign p1_b = v[31:0] * ght_pkg::MIX_B[63:32];
	assign p2_b = v[63:32] * ght_pkg::MIX_B[31:0];
	assign cross_b = p1_s4 + p2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		z_s1   <= in_x + ght_pkg::GOLDEN;
		res_s1 <= in_res;
		p0_s2  <= p0_a;
		p1_s2  <= p1_a;
		p2_s2  <= p2_a;
		res_s2 <= res_s1;
		w_s3   <= p0_s2 + {cross_a, 32'd0};
		res_s3 <= res_s2;
		p0_s4  <= p0_b;
		p1_s4  <= p1_b;
		p2_s4  <= p2_b;
		res_s4 <= res_s3;
		u_s5   <= p0_s4 + {cross_b, 32'd0};
		res_s5 <= res_s4;
	end

	assign out_valid = vld_s5;
	assign out_res   = res_s5;
	assign out_hash  = u_s5 ^ (u_s5 >> 31);

endmodule

`default_nettype wire

// ===== src/generational_handle_table.sv =====
// generational handle table: slot memory, free list and cookie generation
//
// channel    direction  handshake                 payload
// command    in         start & !busy             operation, handle_index,
//                                                 handle_generation, task_tag
// result     out        done (one-cycle strobe)   status, slot_index,
//                                                 slot_generation, stored_tag, cookie
// config     in         psel & penable & pwrite   paddr, pwdata (prdata on read)
//
// transactions do not overlap: the accept cycle issues the slot memory read,
// the next cycle checks the entry and writes it back on the same single port
// (busy is high for that cycle). results leave the hash pipeline through the
// result registers; the cookie hash runs in a 5-stage pipeline beside the state path.
// reset needs no clearing pass: a fill mark tells untouched entries from written
// ones. results cannot be stalled.
`default_nettype none

module generational_handle_table #(
	parameter int SLOTS = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// command channel
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      operation,
	input  wire logic [31:0]                     handle_index,
	input  wire logic [31:0]                     handle_generation,
	input  wire logic [31:0]                     task_tag,
	// result channel
	output logic                                 done,
	output logic [2:0]                           status,
	output logic [ght_pkg::SLOT_INDEX_W-1:0]     slot_index,
	output logic [31:0]                          slot_generation,
	output logic [31:0]                          stored_tag,
	output logic [63:0]                          cookie,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ght_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [63:0]                     pwdata,
	output logic [63:0]                          prdata,
	output logic                                 pready
);

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W = IDX_W + 1;
	localparam int LATENCY = 7;

	// one slot: generation, tag, live mark and free-list link
	typedef struct packed {
		logic [31:0]       gen;
		logic [31:0]       tag;
		logic              live;
		logic [LINK_W-1:0] link;
	} entry_t;

	// configuration
	logic [63:0] secret_q;
	logic        cfg_wr;
	logic        cfg_sel;

	// list and cookie state
	logic [LINK_W-1:0] free_top_q;   // head of free list, SLOTS when empty
	logic [LINK_W-1:0] fresh_q;      // entries at or above this were never written
	logic [63:0]       gold_acc_q;   // cookie counter times golden constant

	// slot memory
	entry_t            mem [SLOTS];
	entry_t            rd_data_s1;
	logic [IDX_W-1:0]  rd_addr;
	logic              accept;

	// stage 1 (read-modify-write)
	logic              busy_q;
	logic [1:0]        op_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic              range_bad_s1;
	logic [31:0]       hgen_s1;
	logic [31:0]       tag_s1;

	entry_t            ent;
	logic              untouched;
	logic              full;
	logic [31:0]       idx32;
	ght_pkg::res_t     res_d;
	logic [63:0]       x_d;
	logic              wr_en;
	entry_t            wr_data;
	logic [LINK_W-1:0] top_d;
	logic              fresh_inc;
	logic              acc_inc;

	// hash pipeline outputs
	logic              mix_valid;
	ght_pkg::res_t     mix_res;
	logic [63:0]       mix_hash;

	// output registers
	logic              done_q;
	ght_pkg::res_t     out_q;
	logic [63:0]       cookie_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[3:3] == ght_pkg::REG_COOKIE_SECRET);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
	assign prdata  = cfg_sel ? secret_q : 64'd0;

	// ---------------- command acceptance ----------------
	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// allocate reads the free head, the others read the addressed slot
	assign rd_addr = (operation == ght_pkg::OP_ALLOC) ? free_top_q[IDX_W-1:0]
	                                                  : handle_index[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= operation;
			addr_s1      <= rd_addr;
			range_bad_s1 <= (handle_index >= 32'(SLOTS));
			hgen_s1      <= handle_generation;
			tag_s1       <= task_tag;
		end
	end

	// ---------------- stage 1: check and write back ----------------
	// an untouched entry reads as its reset value: generation one, not live,
	// linked to the next index
	assign untouched = ({1'b0, addr_s1} >= fresh_q);
	assign full      = (free_top_q >= LINK_W'(SLOTS));
	assign idx32     = 32'(addr_s1);

	always_comb begin
		if (untouched) begin
			ent.gen  = 32'd1;
			ent.tag  = 32'd0;
			ent.live = 1'b0;
			ent.link = LINK_W'(addr_s1) + LINK_W'(1);
		end else begin
			ent = rd_data_s1;
		end
	end

	always_comb begin
		res_d     = '0;
		x_d       = '0;
		wr_en     = 1'b0;
		wr_data   = ent;
		top_d     = free_top_q;
		fresh_inc = 1'b0;
		acc_inc   = 1'b0;
		if (busy_q) begin
			unique case (op_s1) inside
				ght_pkg::OP_ALLOC: begin
					if (full) begin
						res_d.status = ght_pkg::ST_FULL;
					end else begin
						res_d.status          = ght_pkg::ST_OK;
						res_d.slot_index      = idx32[ght_pkg::SLOT_INDEX_W-1:0];
						res_d.slot_generation = ent.gen;
						res_d.stored_tag      = tag_s1;
						res_d.cookie_en       = 1'b1;
						wr_en        = 1'b1;
						wr_data.tag  = tag_s1;
						wr_data.live = 1'b1;
						top_d        = ent.link;
						fresh_inc    = untouched;
						acc_inc      = 1'b1;
						x_d = {idx32, 32'd0} ^ {32'd0, ent.gen} ^ gold_acc_q ^ secret_q;
					end
				end
				ght_pkg::OP_RESOLVE, ght_pkg::OP_CONSUME: begin
					if (range_bad_s1) begin
						res_d.status = ght_pkg::ST_RANGE;
					end else begin
						res_d.slot_index      = idx32[ght_pkg::SLOT_INDEX_W-1:0];
						res_d.slot_generation = ent.gen;
						if (ent.gen != hgen_s1) begin
							res_d.status = ght_pkg::ST_STALE;
						end else if (!ent.live) begin
							res_d.status = ght_pkg::ST_NOT_LIVE;
						end else if (op_s1 == ght_pkg::OP_RESOLVE) begin
							res_d.status     = ght_pkg::ST_OK;
							res_d.stored_tag = ent.tag;
						end else if (ent.tag != tag_s1) begin
							res_d.status = ght_pkg::ST_TAG;
						end else begin
							// free the slot: bump generation, push on the list
							res_d.status     = ght_pkg::ST_OK;
							res_d.stored_tag = ent.tag;
							wr_en        = 1'b1;
							wr_data.gen  = ent.gen + 32'd1;
							wr_data.live = 1'b0;
							wr_data.link = free_top_q;
							top_d        = {1'b0, addr_s1};
						end
					end
				end
				default: begin
					res_d.status = ght_pkg::ST_RANGE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			secret_q   <= 64'd0;
			free_top_q <= '0;
			fresh_q    <= '0;
			gold_acc_q <= ght_pkg::GOLDEN;
		end else begin
			busy_q     <= accept;
			free_top_q <= top_d;
			if (cfg_wr) begin
				secret_q <= pwdata;
			end
			if (fresh_inc) begin
				fresh_q <= fresh_q + LINK_W'(1);
			end
			if (acc_inc) begin
				gold_acc_q <= gold_acc_q + ght_pkg::GOLDEN;
			end
		end
	end

	// ---------------- cookie hash ----------------
	ght_mix64 u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (busy_q),
		.in_x      (x_d),
		.in_res    (res_d),
		.out_valid (mix_valid),
		.out_res   (mix_res),
		.out_hash  (mix_hash)
	);

	// ---------------- result registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mix_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_q    <= mix_res;
		cookie_q <= mix_res.cookie_en ? mix_hash : 64'd0;
	end

	assign done            = done_q;
	assign status          = out_q.status;
	assign slot_index      = out_q.slot_index;
	assign slot_generation = out_q.slot_generation;
	assign stored_tag      = out_q.stored_tag;
	assign cookie          = cookie_q;

`ifndef NO_ASSERTIONS
	// the single memory port relies on a gap cycle between transactions
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("back-to-back read-modify-write on slot memory");

	// free head is a written slot or the fill mark, which never passes the end
	a_list: assert property (@(posedge clk) disable iff (!arst_n)
		(free_top_q <= fresh_q) && (fresh_q <= LINK_W'(SLOTS)))
		else $error("free list head beyond fill mark");

	// every accepted command gets its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing");
`endif

endmodule

`default_nettype wire
